### hdl/task_slot_scheduler_defines.svh
// Assertion macros for the task slot scheduler
`ifndef TASK_SLOT_SCHEDULER_DEFINES_SVH
`define TASK_SLOT_SCHEDULER_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define TSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle
`define TSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/tss_pkg.sv
// Shared types and constants of the task slot scheduler
`timescale 1ns / 1ps
`default_nettype none
package tss_pkg;

  localparam int OP_W     = 3;
  localparam int ID_W     = 8;
  localparam int PRIO_W   = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;
  localparam int SLICE_W  = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_BLOCK   = 3'd2,
    OP_UNBLOCK = 3'd3,
    OP_TICK    = 3'd4,
    OP_YIELD   = 3'd5
  } op_t;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SCHED_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_LENGTH = 1'd1;

  localparam logic MODE_RR = 1'b0;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;

  // One slot table entry
  typedef struct packed {
    logic [ID_W-1:0]    task_id;
    logic [PRIO_W-1:0]  prio;
    logic               ready;
    logic [SLICE_W-1:0] slice_left;
  } slot_word_t;

endpackage
`default_nettype wire

### hdl/tss_if.sv
// Request and response channel interfaces of the task slot scheduler
`timescale 1ns / 1ps
`default_nettype none
interface tss_req_if;
  logic                        valid;
  logic                        ready;
  logic [tss_pkg::OP_W-1:0]    op;
  logic [tss_pkg::ID_W-1:0]    task_id;
  logic [tss_pkg::PRIO_W-1:0]  task_priority;
  modport source (output valid, op, task_id, task_priority, input ready);
  modport sink (input valid, op, task_id, task_priority, output ready);
endinterface

interface tss_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tss_pkg::STATUS_W-1:0]  status;
  logic                          current_valid;
  logic [tss_pkg::ID_W-1:0]      current_id;
  logic                          switched;
  logic [tss_pkg::COUNT_W-1:0]   task_count;
  modport source (output valid, status, current_valid, current_id, switched, task_count,
                  input ready);
  modport sink (input valid, status, current_valid, current_id, switched, task_count,
                output ready);
endinterface
`default_nettype wire

### hdl/task_slot_scheduler.sv
// Task slot scheduler: slot table in one memory, scanned one slot a cycle
//
//   channel | dir | handshake    | carries
//   req     | in  | valid/ready  | op, task_id, task_priority
//   rsp     | out | valid/ready  | status, current_valid, current_id, switched, task_count
//   cfg     | in  | cfg_wr_en    | cfg_index, cfg_data
//
// Add, remove, block and unblock scan the table, one slot read per cycle, until a match
// or the last slot; a full add, a yield with no task and an unknown op skip to the result.
// A tick with a task running does a read-modify-write of the running slot; with none it
// does a selection scan. A tick or yield that expires the slice does the read-modify-write,
// then a selection scan (round robin stops at the first ready slot). The memory has a
// single read port. Synchronous reset clears the used flags and counters at once; no
// clearing pass. A new item is taken while a result waits, and the next request is
// accepted in the cycle after a result loads; a stalled output holds the block in S_FIN.
`timescale 1ns / 1ps
`default_nettype none
`include "task_slot_scheduler_defines.svh"
module task_slot_scheduler #(
  parameter int SLOT_COUNT = 32
) (
  input  wire                           clk,
  input  wire                           rst,
  tss_req_if.sink                       req,
  tss_rsp_if.source                     rsp,
  input  wire                           cfg_wr_en,
  input  wire [tss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [tss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tss_pkg::*;

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int MW = $bits(slot_word_t);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FIND   = 6'b000010,
    S_RUN_RD = 6'b000100,
    S_RUN_WB = 6'b001000,
    S_PICK   = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t                state;
  logic [MW-1:0]         slot_mem [SLOT_COUNT];
  logic [MW-1:0]         rd_data;
  logic [SLOT_COUNT-1:0] slot_used;
  logic [CW-1:0]         used_count;
  logic [IW-1:0]         scan_head;
  logic [IW-1:0]         running_slot;
  logic                  running_valid;
  logic [ID_W-1:0]       cur_task;
  logic                  sched_mode;
  logic [SLICE_W-1:0]    slice_length;

  op_t                   op_q;
  logic [ID_W-1:0]       id_q;
  logic [PRIO_W-1:0]     prio_q;
  logic [STATUS_W-1:0]   status_q;
  logic                  sw_q;

  logic [IW-1:0]         scan_base;
  logic [CW-1:0]         iss_cnt;
  logic                  rd_vld;
  logic [IW-1:0]         rd_idx;
  logic                  rd_last;
  logic                  best_vld;
  logic [IW-1:0]         best_slot;
  logic [PRIO_W-1:0]     top_prio;
  logic [ID_W-1:0]       best_task;

  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic                  out_cur_valid;
  logic [ID_W-1:0]       out_cur_id;
  logic                  out_sw;
  logic [COUNT_W-1:0]    out_count;

  slot_word_t            rd_word;
  logic                  rd_used;
  logic [IW:0]           addr_sum;
  logic [IW-1:0]         scan_addr;
  logic [IW:0]           head_sum;
  logic [IW-1:0]         head_next;
  logic                  cand;
  logic                  better;
  logic                  pick_end;
  logic                  find_hit;
  logic                  find_miss;
  logic                  expire;
  logic                  f_vld;
  logic [IW-1:0]         f_slot;
  logic [ID_W-1:0]       f_task;
  logic                  mem_we;
  logic [IW-1:0]         mem_wa;
  slot_word_t            mem_wd;
  logic [IW-1:0]         mem_ra;

  // Decode the slot under scan
  always_comb begin
    rd_word  = slot_word_t'(rd_data);
    rd_used  = slot_used[rd_idx];
    addr_sum = {1'b0, scan_base} + {1'b0, iss_cnt[IW-1:0]};
    if (addr_sum >= (IW+1)'(SLOT_COUNT)) begin
      addr_sum = addr_sum - (IW+1)'(SLOT_COUNT);
    end
    scan_addr = addr_sum[IW-1:0];
    head_sum  = {1'b0, rd_idx} + (IW+1)'(1);
    head_next = (head_sum == (IW+1)'(SLOT_COUNT)) ? '0 : head_sum[IW-1:0];
    cand      = rd_vld && rd_used && rd_word.ready;
    better    = cand && (!best_vld || (rd_word.prio > top_prio));
    pick_end  = rd_vld && (rd_last || ((sched_mode == MODE_RR) && cand));
    find_hit  = rd_vld && ((op_q == OP_ADD) ? !rd_used
                                           : (rd_used && (rd_word.task_id == id_q)));
    find_miss = rd_vld && !find_hit && rd_last;
    expire    = (op_q == OP_YIELD) || (rd_word.slice_left <= SLICE_W'(1));
    f_vld     = best_vld || better;
    f_slot    = better ? rd_idx : best_slot;
    f_task    = better ? rd_word.task_id : best_task;
  end

  // Select memory write and read
  always_comb begin
    mem_we = 1'b0;
    mem_wa = rd_idx;
    mem_wd = rd_word;
    mem_ra = (state == S_RUN_RD) ? running_slot : scan_addr;
    case (state)
      S_FIND: begin
        if (find_hit) begin
          case (op_q)
            OP_ADD: begin
              mem_we = 1'b1;
              mem_wd = '{task_id: id_q, prio: prio_q, ready: 1'b1,
                         slice_left: slice_length};
            end
            OP_BLOCK, OP_UNBLOCK: begin
              mem_we       = 1'b1;
              mem_wd.ready = (op_q == OP_UNBLOCK);
            end
            default: begin
              mem_we = 1'b0;
            end
          endcase
        end
      end
      S_RUN_WB: begin
        mem_we            = 1'b1;
        mem_wa            = running_slot;
        mem_wd.slice_left = expire ? slice_length : rd_word.slice_left - SLICE_W'(1);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Slot table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    rd_data <= slot_mem[mem_ra];
  end

  // Sequencer and scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_used     <= '0;
      used_count    <= '0;
      scan_head     <= '0;
      running_slot  <= '0;
      running_valid <= 1'b0;
      sched_mode    <= 1'b0;
      slice_length  <= SLICE_RESET;
      iss_cnt       <= '0;
      rd_vld        <= 1'b0;
      best_vld      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // take register writes
      if (cfg_wr_en) begin
        if (cfg_index == REG_SCHED_MODE) begin
          sched_mode <= cfg_data[0];
        end else if (cfg_index == REG_SLICE_LENGTH) begin
          slice_length <= cfg_data[SLICE_W-1:0];
        end
      end
      // drop the result once transferred
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      // issue one slot read per cycle while scanning
      if ((state == S_FIND) || (state == S_PICK)) begin
        if (iss_cnt != CW'(SLOT_COUNT)) begin
          rd_vld  <= 1'b1;
          rd_idx  <= scan_addr;
          rd_last <= (iss_cnt == CW'(SLOT_COUNT - 1));
          iss_cnt <= iss_cnt + CW'(1);
        end else begin
          rd_vld <= 1'b0;
        end
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_q      <= op_t'(req.op);
            id_q      <= req.task_id;
            prio_q    <= req.task_priority;
            status_q  <= ST_OK;
            sw_q      <= 1'b0;
            iss_cnt   <= '0;
            rd_vld    <= 1'b0;
            best_vld  <= 1'b0;
            scan_base <= '0;
            case (op_t'(req.op))
              OP_ADD: begin
                if (used_count >= CW'(SLOT_COUNT)) begin
                  status_q <= ST_FULL;
                  state    <= S_FIN;
                end else begin
                  state <= S_FIND;
                end
              end
              OP_REMOVE, OP_BLOCK, OP_UNBLOCK: begin
                state <= S_FIND;
              end
              OP_TICK: begin
                if (running_valid) begin
                  state <= S_RUN_RD;
                end else begin
                  scan_base <= scan_head;
                  state     <= S_PICK;
                end
              end
              OP_YIELD: begin
                state <= running_valid ? S_RUN_RD : S_FIN;
              end
              default: begin
                status_q <= ST_UNKNOWN;
                state    <= S_FIN;
              end
            endcase
          end
        end
        S_FIND: begin
          if (find_hit) begin
            rd_vld <= 1'b0;
            state  <= S_FIN;
            if (op_q == OP_ADD) begin
              slot_used[rd_idx] <= 1'b1;
              used_count        <= used_count + CW'(1);
            end else if (op_q == OP_REMOVE) begin
              slot_used[rd_idx] <= 1'b0;
              used_count        <= used_count - CW'(1);
              if (running_valid && (running_slot == rd_idx)) begin
                running_valid <= 1'b0;
                sw_q          <= 1'b1;
              end
            end
          end else if (find_miss) begin
            rd_vld   <= 1'b0;
            status_q <= ST_NOT_FOUND;
            state    <= S_FIN;
          end
        end
        S_RUN_RD: begin
          state <= S_RUN_WB;
        end
        S_RUN_WB: begin
          if (expire) begin
            scan_base <= scan_head;
            iss_cnt   <= '0;
            rd_vld    <= 1'b0;
            best_vld  <= 1'b0;
            state     <= S_PICK;
          end else begin
            state <= S_FIN;
          end
        end
        S_PICK: begin
          // track the best ready slot; round robin stops at the first one
          if (better) begin
            best_vld  <= 1'b1;
            best_slot <= rd_idx;
            top_prio  <= rd_word.prio;
            best_task <= rd_word.task_id;
          end
          if (cand && (sched_mode == MODE_RR)) begin
            scan_head <= head_next;
          end
          if (pick_end) begin
            rd_vld <= 1'b0;
            state  <= S_FIN;
            if (f_vld && (!running_valid || (f_slot != running_slot))) begin
              running_slot  <= f_slot;
              running_valid <= 1'b1;
              cur_task      <= f_task;
              sw_q          <= 1'b1;
            end
          end
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid     <= 1'b1;
            out_status    <= status_q;
            out_cur_valid <= running_valid;
            out_cur_id    <= running_valid ? cur_task : '0;
            out_sw        <= sw_q;
            out_count     <= COUNT_W'(used_count);
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Drive the channels
  assign req.ready         = (state == S_IDLE) && !rst;
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.current_valid = out_cur_valid;
  assign rsp.current_id    = out_cur_id;
  assign rsp.switched      = out_sw;
  assign rsp.task_count    = out_count;

  `TSS_ASSERT_NOW(a_count_bound, 1'b1, used_count <= CW'(SLOT_COUNT), "used count exceeds slots")
  `TSS_ASSERT_NOW(a_count_match, 1'b1, used_count == CW'($countones(slot_used)), "count mismatch")
  `TSS_ASSERT_NOW(a_running_used, running_valid, slot_used[running_slot], "running slot free")
  `TSS_ASSERT_NEXT(a_busy_after, req.valid && req.ready, state != S_IDLE, "idle after transfer")

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the task slot scheduler
`timescale 1ns / 1ps
module tb;
  import tss_pkg::*;

  localparam int SLOTS = 32;
  localparam int DRAIN_CYCLES = SLOTS + 10;
  localparam int STALL_LIMIT = 5000;
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                current_valid;
    logic [ID_W-1:0]     current_id;
    logic                switched;
    logic [COUNT_W-1:0]  task_count;
  } sched_result_t;

  // Predicts the scheduler's response to each transfer and checks the results
  class sched_scoreboard;
    bit                 used[SLOTS];
    logic [ID_W-1:0]    tid[SLOTS];
    logic [PRIO_W-1:0]  prio[SLOTS];
    bit                 rdy[SLOTS];
    logic [SLICE_W-1:0] left[SLOTS];
    int                 head;
    int                 run_slot;
    bit                 run_valid;
    int                 count;
    logic               mode;
    logic [SLICE_W-1:0] slice_len;
    sched_result_t      pending[$];
    int                 errors;

    function new();
      foreach (used[i]) used[i] = 0;
      head = 0;
      run_slot = 0;
      run_valid = 0;
      count = 0;
      mode = MODE_RR;
      slice_len = SLICE_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_SCHED_MODE) mode = data[0];
      else slice_len = data;
    endfunction

    function int find_slot(logic [ID_W-1:0] id);
      for (int i = 0; i < SLOTS; i++)
        if (used[i] && tid[i] == id) return i;
      return -1;
    endfunction

    // Pick the next ready slot; round robin advances the head
    function int choose_slot();
      int best;
      int s;
      best = -1;
      if (count == 0) return -1;
      for (int i = 0; i < SLOTS; i++) begin
        s = (head + i) % SLOTS;
        if (!used[s] || !rdy[s]) continue;
        if (mode == MODE_RR) begin
          head = (s + 1) % SLOTS;
          return s;
        end
        if (best < 0 || prio[s] > prio[best]) best = s;
      end
      return best;
    endfunction

    // Count down the running slice; reselect when it expires or when no task runs
    function bit advance_slice();
      int nxt;
      if (!run_valid) begin
        nxt = choose_slot();
        if (nxt < 0) return 0;
        run_slot = nxt;
        run_valid = 1;
        return 1;
      end
      if (left[run_slot] > 1) begin
        left[run_slot]--;
        return 0;
      end
      left[run_slot] = slice_len;
      nxt = choose_slot();
      if (nxt >= 0 && nxt != run_slot) begin
        run_slot = nxt;
        return 1;
      end
      return 0;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                               logic [PRIO_W-1:0] pr);
      sched_result_t r;
      int s;
      r = '0;
      r.status = ST_OK;
      case (op)
        OP_ADD: begin
          if (count >= SLOTS) r.status = ST_FULL;
          else begin
            for (int i = 0; i < SLOTS; i++)
              if (!used[i]) begin
                used[i] = 1;
                tid[i] = id;
                prio[i] = pr;
                rdy[i] = 1;
                left[i] = slice_len;
                count++;
                break;
              end
          end
        end
        OP_REMOVE: begin
          s = find_slot(id);
          if (s < 0) r.status = ST_NOT_FOUND;
          else begin
            used[s] = 0;
            count--;
            if (run_valid && run_slot == s) begin
              run_valid = 0;
              r.switched = 1;
            end
          end
        end
        OP_BLOCK, OP_UNBLOCK: begin
          s = find_slot(id);
          if (s < 0) r.status = ST_NOT_FOUND;
          else rdy[s] = (op == OP_UNBLOCK);
        end
        OP_TICK: r.switched = advance_slice();
        OP_YIELD: begin
          if (run_valid) begin
            left[run_slot] = '0;
            r.switched = advance_slice();
          end
        end
        default: r.status = ST_UNKNOWN;
      endcase
      r.current_valid = run_valid;
      r.current_id = run_valid ? tid[run_slot] : '0;
      r.task_count = count[COUNT_W-1:0];
      pending.push_back(r);
    endfunction

    function void check_response(sched_result_t got);
      sched_result_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result transfer %p", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.current_valid !== exp.current_valid) begin
        $error("current_valid: expected %0d, got %0d", exp.current_valid, got.current_valid);
        errors++;
      end
      if (got.current_id !== exp.current_id) begin
        $error("current_id: expected %0d, got %0d", exp.current_id, got.current_id);
        errors++;
      end
      if (got.switched !== exp.switched) begin
        $error("switched: expected %0d, got %0d", exp.switched, got.switched);
        errors++;
      end
      if (got.task_count !== exp.task_count) begin
        $error("task_count: expected %0d, got %0d", exp.task_count, got.task_count);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit quiet;
  int stall_left;
  int idle_cycles;
  sched_scoreboard sb;

  tss_req_if req_ch();
  tss_rsp_if rsp_ch();

  task_slot_scheduler #(.SLOT_COUNT(SLOTS)) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Note accepted requests and check accepted results
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      sb.note_request(req_ch.op, req_ch.task_id, req_ch.task_priority);
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_response('{rsp_ch.status, rsp_ch.current_valid, rsp_ch.current_id,
                          rsp_ch.switched, rsp_ch.task_count});
  end

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 14);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic send(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] pr);
    int gap;
    gap = (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.task_id <= id;
    req_ch.task_priority <= pr;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Hold off until every result is back and the block is idle
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    return ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 15));
  endfunction

  // Mix mostly valid operations on a small id set with some noise
  task automatic random_items(int n);
    int r;
    logic [OP_W-1:0] op;
    logic [PRIO_W-1:0] pr;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < ((sb.count < SLOTS) ? 28 : 8)) op = OP_ADD;
      else if (r < 42) op = OP_REMOVE;
      else if (r < 52) op = OP_BLOCK;
      else if (r < 64) op = OP_UNBLOCK;
      else if (r < 88) op = OP_TICK;
      else if (r < 96) op = OP_YIELD;
      else op = ($urandom_range(0, 1) != 0) ? OP_SPARE_LO : OP_SPARE_HI;
      pr = ($urandom_range(0, 1) != 0) ? PRIO_W'($urandom) : PRIO_W'($urandom_range(0, 3));
      send(op, pick_id(), pr);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    quiet = 0;
    stall_left = 0;
    idle_cycles = 0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_TICK;
    req_ch.task_id = '0;
    req_ch.task_priority = '0;
    rsp_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, extremes, duplicates, blocking, removal, unknown ops
    send(OP_YIELD, 8'd0, 8'd0);
    send(OP_TICK, 8'd0, 8'd0);
    send(OP_REMOVE, 8'd77, 8'd0);
    send(OP_ADD, 8'd0, 8'd0);
    send(OP_ADD, 8'd255, 8'd255);
    send(OP_ADD, 8'd255, 8'd128);
    send(OP_TICK, 8'd0, 8'd0);
    send(OP_TICK, 8'd0, 8'd0);
    send(OP_YIELD, 8'd0, 8'd0);
    send(OP_BLOCK, 8'd255, 8'd0);
    send(OP_YIELD, 8'd0, 8'd0);
    send(OP_YIELD, 8'd0, 8'd0);
    send(OP_UNBLOCK, 8'd255, 8'd0);
    send(OP_BLOCK, 8'd9, 8'd0);
    send(OP_UNBLOCK, 8'd9, 8'd0);
    send(OP_REMOVE, 8'd0, 8'd0);
    send(OP_YIELD, 8'd0, 8'd0);
    send(OP_REMOVE, 8'd255, 8'd0);
    send(OP_SPARE_LO, 8'd255, 8'd255);
    send(OP_SPARE_HI, 8'd0, 8'd0);
    send(OP_TICK, 8'd0, 8'd0);
    drain();

    // Priority mode with one-tick slices; fill the table past full
    write_reg(REG_SCHED_MODE, 16'd1);
    write_reg(REG_SLICE_LENGTH, 16'd1);
    for (int k = 0; k < SLOTS + 2; k++)
      send(OP_ADD, ID_W'(k), PRIO_W'($urandom));
    random_items(260);
    drain();

    // Round robin with the longest slice
    write_reg(REG_SCHED_MODE, 16'd0);
    write_reg(REG_SLICE_LENGTH, 16'hFFFF);
    random_items(300);
    drain();

    // Short slices, then a stretch with no idling at all
    write_reg(REG_SCHED_MODE, 16'd1);
    write_reg(REG_SLICE_LENGTH, 16'd3);
    random_items(170);
    quiet = 1;
    random_items(170);
    drain();

    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
